// File: design/tcw_pkg.sv
// Shared types, codes and constants of the text console character writer.
package tcw_pkg;

  localparam int ROW_W   = 6;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int OP_W    = 2;
  localparam int ROWS_W  = 7;
  localparam int KIND_W  = 4;

  localparam int MAX_ROWS_DEF = 50;
  localparam int COLUMNS_DEF  = 80;

  localparam logic [ROW_W-1:0] ROW_COUNT_RESET = 6'd25;

  localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam logic [CHAR_W-1:0] CH_BELL  = 8'h07;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  // Command classes handed from the front to the back.
  localparam logic [KIND_W-1:0] K_NOP   = 4'd0;
  localparam logic [KIND_W-1:0] K_FF    = 4'd1;
  localparam logic [KIND_W-1:0] K_CR    = 4'd2;
  localparam logic [KIND_W-1:0] K_LF    = 4'd3;
  localparam logic [KIND_W-1:0] K_BS    = 4'd4;
  localparam logic [KIND_W-1:0] K_BELL  = 4'd5;
  localparam logic [KIND_W-1:0] K_WRITE = 4'd6;
  localparam logic [KIND_W-1:0] K_MOVE  = 4'd7;
  localparam logic [KIND_W-1:0] K_READ  = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              beep;
    logic [CHAR_W-1:0] cell_char;
  } out_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

endpackage

// File: design/tcw_front.sv
// Front end: accepts input transactions, classifies them, queues commands.
module tcw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            enable,
  input  logic            in_valid,
  output logic            in_ready,
  input  tcw_pkg::in_t    in_data,
  output logic            head_valid,
  output tcw_pkg::cmd_t   head,
  input  logic            pop
);

  function automatic tcw_pkg::cmd_t classify(input tcw_pkg::in_t d);
    tcw_pkg::cmd_t c;
    c.kind = tcw_pkg::K_NOP;
    c.ch   = d.char_code;
    c.row  = d.row;
    c.col  = d.col;
    unique case (d.op)
      tcw_pkg::OP_PUT: begin
        unique case (d.char_code)
          tcw_pkg::CH_FF:   c.kind = tcw_pkg::K_FF;
          tcw_pkg::CH_CR:   c.kind = tcw_pkg::K_CR;
          tcw_pkg::CH_LF:   c.kind = tcw_pkg::K_LF;
          tcw_pkg::CH_BS:   c.kind = tcw_pkg::K_BS;
          tcw_pkg::CH_BELL: c.kind = tcw_pkg::K_BELL;
          tcw_pkg::CH_TAB: begin
            c.kind = tcw_pkg::K_WRITE;
            c.ch   = tcw_pkg::CH_BLANK;
          end
          default:          c.kind = tcw_pkg::K_WRITE;
        endcase
      end
      tcw_pkg::OP_MOVE: c.kind = tcw_pkg::K_MOVE;
      tcw_pkg::OP_READ: c.kind = tcw_pkg::K_READ;
      default:          c.kind = tcw_pkg::K_NOP;
    endcase
    return c;
  endfunction

  tcw_pkg::cmd_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready   = enable && (count != 2'd2);
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= classify(in_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/tcw_back.sv
// Back end: cursor, row map and screen memory, executes commands and drives results.
module tcw_back #(
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [tcw_pkg::ROW_W-1:0] cfg_data,
  input  logic                      head_valid,
  input  tcw_pkg::cmd_t             head,
  output logic                      pop,
  output logic                      init_done,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tcw_pkg::out_t             out_data
);

  localparam int CELL_COUNT = MAX_ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int MAP_AW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ROW_W      = tcw_pkg::ROW_W;
  localparam int COL_W      = tcw_pkg::COL_W;
  localparam int ROWS_W     = tcw_pkg::ROWS_W;
  localparam logic [ROW_W-1:0]  ROW_LAST_MAX = ROW_W'(MAX_ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
  localparam logic [COL_W:0]    COLS_WIDE    = (COL_W + 1)'(COLUMNS);
  localparam logic [ROWS_W-1:0] ROWS_MAX     = ROWS_W'(MAX_ROWS);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_MAPRD = 4'd4;
  localparam logic [3:0] S_BLANK = 4'd5;
  localparam logic [3:0] S_ROT0  = 4'd6;
  localparam logic [3:0] S_ROT1  = 4'd7;
  localparam logic [3:0] S_ROTW  = 4'd8;
  localparam logic [3:0] S_ROTL  = 4'd9;

  logic [tcw_pkg::CHAR_W-1:0] cells [CELL_COUNT];
  logic [MAP_AW-1:0]          row_map [MAX_ROWS];

  logic [3:0]          state;
  logic [ROW_W-1:0]    row_count;
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W-1:0]    cur_col;
  tcw_pkg::cmd_t       cmd;
  logic [ROW_W-1:0]    sweep_row;
  logic [ROW_W-1:0]    sweep_last;
  logic [COL_W-1:0]    sc;
  logic [ROW_W-1:0]    rot_idx;
  logic [MAP_AW-1:0]   first;
  logic [MAP_AW-1:0]   map_q;
  logic [tcw_pkg::CHAR_W-1:0] cell_q;

  logic [ROWS_W-1:0]   rows;
  logic [ROW_W-1:0]    last_row;
  logic [ROW_W-1:0]    row_cl;
  logic                slot_free;
  logic                in_range;
  logic                out_load;
  logic [ROW_W-1:0]    row_n;
  logic [COL_W-1:0]    col_n;
  logic                beep_n;
  logic                wr;
  logic [tcw_pkg::CHAR_W-1:0] wch;
  logic                lf;
  logic                scroll;
  logic [COL_W:0]      col_inc;
  logic [COL_W-1:0]    exec_col;
  logic [COL_W-1:0]    col_sel;
  logic [ADDR_W-1:0]   row_base;
  logic [ADDR_W-1:0]   cell_addr;
  logic [ROW_W-1:0]    map_rrow;
  logic [ROW_W-1:0]    rot_rd;
  logic [MAP_AW-1:0]   map_raddr;
  logic                map_we;
  logic [MAP_AW-1:0]   map_waddr;
  logic [MAP_AW-1:0]   map_wdata;
  logic                cell_we;
  logic [tcw_pkg::CHAR_W-1:0] cell_wdata;

  // Rows in use: the register saturated to 1..MAX_ROWS.
  always_comb begin
    if (row_count == '0) begin
      rows = ROWS_W'(1);
    end else if ({1'b0, row_count} > ROWS_MAX) begin
      rows = ROWS_MAX;
    end else begin
      rows = {1'b0, row_count};
    end
  end

  assign last_row  = ROW_W'(rows - ROWS_W'(1));
  assign row_cl    = ({1'b0, cur_row} >= rows) ? last_row : cur_row;
  assign slot_free = !out_valid || out_ready;
  assign in_range  = ({1'b0, cmd.row} < rows) && ({1'b0, cmd.col} < COLS_WIDE);
  assign col_inc   = {1'b0, cur_col} + (COL_W + 1)'(1);
  assign pop       = (state == S_IDLE) && head_valid;

  // Post a result: from the read state, or from execute unless an in-range read still waits for its data.
  assign out_load  = slot_free && ((state == S_READ) ||
                     ((state == S_EXEC) && !((cmd.kind == tcw_pkg::K_READ) && in_range)));

  // Result of one command in the execute state.
  always_comb begin
    row_n  = cur_row;
    col_n  = cur_col;
    beep_n = 1'b0;
    wr     = 1'b0;
    wch    = cmd.ch;
    lf     = 1'b0;
    scroll = 1'b0;
    unique case (cmd.kind)
      tcw_pkg::K_BELL: beep_n = 1'b1;
      tcw_pkg::K_CR:   col_n  = '0;
      tcw_pkg::K_LF:   lf     = 1'b1;
      tcw_pkg::K_BS: begin
        if (cur_col != '0) begin
          col_n = cur_col - COL_W'(1);
          wr    = 1'b1;
          wch   = tcw_pkg::CH_BLANK;
        end else begin
          beep_n = 1'b1;
        end
      end
      tcw_pkg::K_WRITE: begin
        wr = 1'b1;
        if (col_inc >= COLS_WIDE) begin
          col_n = '0;
          lf    = 1'b1;
        end else begin
          col_n = col_inc[COL_W-1:0];
        end
      end
      tcw_pkg::K_FF: begin
        row_n = '0;
        col_n = '0;
      end
      tcw_pkg::K_MOVE: begin
        if (in_range) begin
          row_n = cmd.row;
          col_n = cmd.col;
        end
      end
      default: ;
    endcase
    if (lf) begin
      if ({1'b0, cur_row} + ROWS_W'(1) < rows) begin
        row_n = cur_row + ROW_W'(1);
      end else begin
        scroll = 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd.kind == tcw_pkg::K_BS) begin
      exec_col = cur_col - COL_W'(1);
    end else if (cmd.kind == tcw_pkg::K_READ) begin
      exec_col = cmd.col;
    end else begin
      exec_col = cur_col;
    end
  end

  // Physical cell address: mapped row times the line length plus column.
  assign col_sel   = (state == S_BLANK) ? sc : exec_col;
  assign row_base  = ADDR_W'(map_q) * ADDR_W'(COLUMNS);
  assign cell_addr = row_base + ADDR_W'(col_sel);
  assign rot_rd    = rot_idx + ROW_W'(2);

  always_comb begin
    unique case (state)
      S_IDLE:  map_rrow = (head.kind == tcw_pkg::K_READ) ? head.row : row_cl;
      S_EXEC:  map_rrow = (cmd.kind == tcw_pkg::K_READ) ? cmd.row : cur_row;
      S_READ:  map_rrow = (cmd.kind == tcw_pkg::K_READ) ? cmd.row : cur_row;
      S_ROT0:  map_rrow = '0;
      S_ROT1:  map_rrow = ROW_W'(1);
      S_ROTW:  map_rrow = rot_rd;
      default: map_rrow = sweep_row;
    endcase
  end

  assign map_raddr = map_rrow[MAP_AW-1:0];

  always_comb begin
    map_we    = 1'b0;
    map_waddr = sweep_row[MAP_AW-1:0];
    map_wdata = sweep_row[MAP_AW-1:0];
    unique case (state)
      S_INIT: map_we = 1'b1;
      S_ROTW: begin
        map_we    = 1'b1;
        map_waddr = rot_idx[MAP_AW-1:0];
        map_wdata = map_q;
      end
      S_ROTL: begin
        map_we    = 1'b1;
        map_waddr = last_row[MAP_AW-1:0];
        map_wdata = first;
      end
      default: ;
    endcase
  end

  assign cell_we    = (state == S_BLANK) || ((state == S_EXEC) && slot_free && wr);
  assign cell_wdata = (state == S_BLANK) ? tcw_pkg::CH_BLANK : wch;

  always_ff @(posedge clk) begin
    if (map_we) begin
      row_map[map_waddr] <= map_wdata;
    end
    map_q <= row_map[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cells[cell_addr] <= cell_wdata;
    end
    cell_q <= cells[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      row_count <= tcw_pkg::ROW_COUNT_RESET;
      cur_row   <= '0;
      cur_col   <= '0;
      sweep_row <= '0;
      out_valid <= 1'b0;
      init_done <= 1'b0;
    end else begin
      if (cfg_we) begin
        row_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (sweep_row == ROW_LAST_MAX) begin
            sweep_row  <= '0;
            sweep_last <= ROW_LAST_MAX;
            state      <= S_MAPRD;
          end else begin
            sweep_row <= sweep_row + ROW_W'(1);
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            cmd     <= head;
            cur_row <= row_cl;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            cur_row <= row_n;
            cur_col <= col_n;
            if (cmd.kind == tcw_pkg::K_READ && in_range) begin
              state <= S_READ;
            end else begin
              out_data.cursor_row <= row_n;
              out_data.cursor_col <= col_n;
              out_data.beep       <= beep_n;
              out_data.cell_char  <= '0;
              if (cmd.kind == tcw_pkg::K_FF) begin
                sweep_row  <= '0;
                sweep_last <= last_row;
                state      <= S_MAPRD;
              end else if (scroll && last_row == '0) begin
                sweep_row  <= '0;
                sweep_last <= '0;
                state      <= S_MAPRD;
              end else if (scroll) begin
                state <= S_ROT0;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end
        S_READ: begin
          if (slot_free) begin
            out_data.cursor_row <= cur_row;
            out_data.cursor_col <= cur_col;
            out_data.beep       <= 1'b0;
            out_data.cell_char  <= cell_q;
            state               <= S_IDLE;
          end
        end
        S_MAPRD: begin
          sc    <= '0;
          state <= S_BLANK;
        end
        S_BLANK: begin
          if (sc == COL_LAST) begin
            if (sweep_row == sweep_last) begin
              init_done <= 1'b1;
              state     <= S_IDLE;
            end else begin
              sweep_row <= sweep_row + ROW_W'(1);
              state     <= S_MAPRD;
            end
          end else begin
            sc <= sc + COL_W'(1);
          end
        end
        S_ROT0: state <= S_ROT1;
        S_ROT1: begin
          first   <= map_q;
          rot_idx <= '0;
          state   <= S_ROTW;
        end
        S_ROTW: begin
          if (rot_idx + ROW_W'(1) == last_row) begin
            state <= S_ROTL;
          end else begin
            rot_idx <= rot_idx + ROW_W'(1);
          end
        end
        S_ROTL: begin
          sweep_row  <= last_row;
          sweep_last <= last_row;
          state      <= S_MAPRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/text_console_char_writer.sv
// Top level of the text console character writer: front end, command queue, back end.
// The back end executes one command at a time, reading the row map and screen memory;
//   the front queue holds up to two more, so input is taken while a scroll or form feed runs.
// Reset: in_ready stays low during a pass that loads the row map and blanks the screen
//   memory, one cell per cycle.
module text_console_char_writer #(
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  tcw_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output tcw_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  logic [tcw_pkg::ROW_W-1:0] cfg_data
);

  // Queue head and handshake between the two halves.
  logic          head_valid;
  tcw_pkg::cmd_t head;
  logic          pop;
  logic          init_done;

  // Front: decode op and control characters into command classes and hold
  // up to two of them, so the CPU can keep writing while a scroll runs.
  tcw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (init_done),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back: the cursor, a logical-to-physical row map and the screen memory.
  // A scroll rotates the row map and blanks one physical row instead of
  // moving the whole screen; the result transaction is posted before the
  // blanking starts.
  tcw_back #(
    .MAX_ROWS (MAX_ROWS),
    .COLUMNS  (COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .init_done  (init_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: design/tcw_checker.sv
// Port-level checks of the text console character writer, bound to the top level.
module tcw_checker #(
  parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF,
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input tcw_pkg::out_t out_data
);

  // Hold a result transaction until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cursor_col < COLUMNS) && (out_data.cursor_row < MAX_ROWS))
    else $error("cursor outside the screen");

  a_beep_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.beep |-> out_data.cell_char == '0)
    else $error("beep together with read data");

endmodule

bind text_console_char_writer tcw_checker #(
  .MAX_ROWS (MAX_ROWS),
  .COLUMNS  (COLUMNS)
) u_tcw_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
